[rtl/core/poq_pkg.sv]
// shared types and constants for the priority outbox queue
`timescale 1ns / 1ps

package poq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int ID_BITS       = 16;
    localparam int PRIORITY_BITS = 2;
    localparam int OP_BITS       = 3;
    localparam int INDEX_BITS    = 4;
    localparam int IDX_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W         = (CNT_W > INDEX_BITS) ? CNT_W : INDEX_BITS;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD      = 3'd0,
        OP_GET_NEXT = 3'd1,
        OP_MARK     = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_CONTAINS = 3'd4,
        OP_READ     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_mode;

    typedef struct packed {
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] pri;
        logic                     pers;
    } t_entry;

    typedef struct packed {
        t_cell_mode               mode;
        logic [IDX_W-1:0]         pos;
        logic [PRIORITY_BITS-1:0] key;
        t_entry                   entry;
    } t_cell_cmd;

    typedef struct packed {
        logic lt;
        logic eq;
        logic keep;
    } t_cell_flags;

endpackage

[rtl/core/priority_outbox_queue_core.sv]
// top level of the priority outbox queue: control sequencer over a chain of entry cells
`timescale 1ns / 1ps
// a request is captured in the idle state, executed in the execute state and its result
//   loaded into the output register from the done state; clear first passes through the
//   clear state, which removes the non-persistent entries one per cycle in the chain
// the next input is taken only back in idle, while a result may still wait for the receiver
// reset (i_rst_n low, synchronous): queue empty, no send in flight, normal priority 1

module priority_outbox_queue_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [poq_pkg::PRIORITY_BITS-1:0]    i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [poq_pkg::OP_BITS-1:0]          i_op,
    input  logic [poq_pkg::ID_BITS-1:0]          i_message_id,
    input  logic [poq_pkg::PRIORITY_BITS-1:0]    i_priority_req,
    input  logic                                 i_persistent,
    input  logic                                 i_sent_ok,
    input  logic [poq_pkg::INDEX_BITS-1:0]       i_index,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_found,
    output logic [poq_pkg::ID_BITS-1:0]          o_out_id,
    output logic [poq_pkg::PRIORITY_BITS-1:0]    o_out_priority,
    output logic                                 o_out_persistent,
    output logic                                 o_in_flight,
    output logic [poq_pkg::CNT_W-1:0]            o_entry_count,
    output logic                                 o_error
);
    import poq_pkg::*;

    // control state
    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_occ, n_occ;
    logic                     r_send, n_send;
    logic [PRIORITY_BITS-1:0] r_norm;
    logic                     r_out_valid, n_out_valid;

    // captured request
    t_op                      r_op;
    logic [ID_BITS-1:0]       r_id;
    logic [PRIORITY_BITS-1:0] r_pri;
    logic                     r_pers;
    logic                     r_ok;
    logic [INDEX_BITS-1:0]    r_idx;

    // result held between execute and the output register
    logic                     r_found, n_found;
    t_entry                   r_rd, n_rd;
    logic                     r_err, n_err;

    // output register
    logic                     r_o_found, n_o_found;
    t_entry                   r_o_entry, n_o_entry;
    logic                     r_o_flight, n_o_flight;
    logic [CNT_W-1:0]         r_o_count, n_o_count;
    logic                     r_o_err, n_o_err;

    // cell chain
    t_cell_cmd                cell_cmd;
    t_entry                   cell_entry [QUEUE_DEPTH];
    t_cell_flags              cell_flags [QUEUE_DEPTH];

    // per-position decode
    logic [QUEUE_DEPTH-1:0]   occupied;
    logic [QUEUE_DEPTH-1:0]   lt_hit;
    logic [QUEUE_DEPTH-1:0]   eq_hit;
    logic [QUEUE_DEPTH-1:0]   drop_hit;
    logic [IDX_W-1:0]         lt_first;
    logic [IDX_W-1:0]         drop_first;
    logic [IDX_W-1:0]         ins_pos;
    logic [IDX_W-1:0]         rd_sel;
    t_entry                   rd_entry;
    logic                     full;
    logic                     idx_in_range;
    logic                     out_free;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_entry left_nb;
            t_entry right_nb;
            // end cells see themselves; an insert never feeds cell 0 from the left,
            // a remove fills the last cell with its own stale value past occupancy
            if (g == 0) begin : g_first
                assign left_nb = cell_entry[g];
            end else begin : g_mid_l
                assign left_nb = cell_entry[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign right_nb = cell_entry[g];
            end else begin : g_mid_r
                assign right_nb = cell_entry[g+1];
            end

            poq_cell u_cell (
                .i_clk      (i_clk),
                .i_cell_idx (IDX_W'(g)),
                .i_cmd      (cell_cmd),
                .i_left     (left_nb),
                .i_right    (right_nb),
                .o_entry    (cell_entry[g]),
                .o_flags    (cell_flags[g])
            );
        end
    endgenerate

    // positions below occupancy hold live entries; flags of other cells are ignored
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            occupied[k] = (CNT_W'(k) < r_occ);
            lt_hit[k]   = occupied[k] & cell_flags[k].lt;
            eq_hit[k]   = occupied[k] & cell_flags[k].eq;
            drop_hit[k] = occupied[k] & ~cell_flags[k].keep;
        end
    end

    // first live entry of lower priority, and first non-persistent entry
    always_comb begin
        lt_first   = '0;
        drop_first = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (lt_hit[k]) begin
                lt_first = IDX_W'(k);
            end
            if (drop_hit[k]) begin
                drop_first = IDX_W'(k);
            end
        end
    end

    assign full         = (r_occ == CNT_W'(QUEUE_DEPTH));
    assign idx_in_range = (CMP_W'(r_idx) < CMP_W'(r_occ));

    // insert point: tail for normal priority or no lower entry, and never ahead of a
    // head that is being sent
    always_comb begin
        if ((r_pri == r_norm) || !(|lt_hit)) begin
            ins_pos = IDX_W'(r_occ);
        end else if (r_send && (lt_first == '0)) begin
            ins_pos = IDX_W'(1);
        end else begin
            ins_pos = lt_first;
        end
    end

    // head for get-next, indexed entry for read
    assign rd_sel   = (r_op == OP_GET_NEXT) ? '0 : IDX_W'(r_idx);
    assign rd_entry = cell_entry[rd_sel];

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // sequencer: next state, cell command, result capture
    always_comb begin
        n_state        = r_state;
        n_occ          = r_occ;
        n_send         = r_send;
        n_found        = r_found;
        n_rd           = r_rd;
        n_err          = r_err;
        n_out_valid    = r_out_valid;
        n_o_found      = r_o_found;
        n_o_entry      = r_o_entry;
        n_o_flight     = r_o_flight;
        n_o_count      = r_o_count;
        n_o_err        = r_o_err;
        cell_cmd.mode  = CELL_HOLD;
        cell_cmd.pos   = '0;
        cell_cmd.key   = r_pri;
        cell_cmd.entry = '{id: r_id, pri: r_pri, pers: r_pers};

        // output transfer frees the register
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_found = 1'b0;
                n_rd    = '0;
                n_err   = 1'b0;
                n_state = ST_DONE;
                unique case (r_op)
                    OP_ADD: begin
                        if (full) begin
                            n_err = 1'b1;
                        end else begin
                            cell_cmd.mode = CELL_INSERT;
                            cell_cmd.pos  = ins_pos;
                            n_occ         = r_occ + CNT_W'(1);
                        end
                    end
                    OP_GET_NEXT: begin
                        if (r_occ != '0) begin
                            n_send  = 1'b1;
                            n_found = 1'b1;
                            n_rd    = rd_entry;
                        end
                    end
                    OP_MARK: begin
                        // head leaves only after a delivered in-flight send
                        if (r_ok && r_send && (r_occ != '0)) begin
                            cell_cmd.mode = CELL_REMOVE;
                            cell_cmd.pos  = '0;
                            n_occ         = r_occ - CNT_W'(1);
                        end
                        n_send = 1'b0;
                    end
                    OP_CLEAR: begin
                        n_state = ST_CLEAR;
                    end
                    OP_CONTAINS: begin
                        n_found = |eq_hit;
                    end
                    OP_READ: begin
                        if (idx_in_range) begin
                            n_found = 1'b1;
                            n_rd    = rd_entry;
                        end
                    end
                    default: begin
                        n_found = 1'b0;
                    end
                endcase
            end
            ST_CLEAR: begin
                // one non-persistent entry squeezed out per cycle, order kept
                if (|drop_hit) begin
                    cell_cmd.mode = CELL_REMOVE;
                    cell_cmd.pos  = drop_first;
                    n_occ         = r_occ - CNT_W'(1);
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait here only while an earlier result still sits unread
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_found;
                    n_o_entry   = r_rd;
                    n_o_flight  = r_send;
                    n_o_count   = r_occ;
                    n_o_err     = r_err;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_send      <= 1'b0;
            r_norm      <= PRIORITY_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_send      <= n_send;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_norm <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op   <= t_op'(i_op);
            r_id   <= i_message_id;
            r_pri  <= i_priority_req;
            r_pers <= i_persistent;
            r_ok   <= i_sent_ok;
            r_idx  <= i_index;
        end
        r_found    <= n_found;
        r_rd       <= n_rd;
        r_err      <= n_err;
        r_o_found  <= n_o_found;
        r_o_entry  <= n_o_entry;
        r_o_flight <= n_o_flight;
        r_o_count  <= n_o_count;
        r_o_err    <= n_o_err;
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_o_found;
    assign o_out_id         = r_o_entry.id;
    assign o_out_priority   = r_o_entry.pri;
    assign o_out_persistent = r_o_entry.pers;
    assign o_in_flight      = r_o_flight;
    assign o_entry_count    = r_o_count;
    assign o_error          = r_o_err;

endmodule

[rtl/core/poq_cell.sv]
// one queue position: holds an entry, shifts with its neighbors, compares priority
`timescale 1ns / 1ps

module poq_cell (
    input  logic                        i_clk,
    input  logic [poq_pkg::IDX_W-1:0]   i_cell_idx,
    input  poq_pkg::t_cell_cmd          i_cmd,
    input  poq_pkg::t_entry             i_left,
    input  poq_pkg::t_entry             i_right,
    output poq_pkg::t_entry             o_entry,
    output poq_pkg::t_cell_flags        o_flags
);
    import poq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.mode)
            CELL_INSERT: begin
                if (i_cell_idx == i_cmd.pos) begin
                    n_entry = i_cmd.entry;
                end else if (i_cell_idx > i_cmd.pos) begin
                    n_entry = i_left;
                end
            end
            CELL_REMOVE: begin
                if (i_cell_idx >= i_cmd.pos) begin
                    n_entry = i_right;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry       = r_entry;
    assign o_flags.lt    = (r_entry.pri < i_cmd.key);
    assign o_flags.eq    = (r_entry.pri == i_cmd.key);
    assign o_flags.keep  = r_entry.pers;

endmodule

[tb/tb_priority_outbox_queue_core.sv]
// self-checking testbench for the priority outbox queue core
`timescale 1ns / 1ps

module tb_priority_outbox_queue_core;
    import poq_pkg::*;

    localparam int SETTLE_CYCLES = 8;      // idle margin once every predicted reply has been checked
    localparam int HOLD_CYCLES   = 400;    // receiver back-pressure stretch
    localparam int STALL_LIMIT   = 3000;   // cycles without any transfer before giving up
    localparam int RANDOM_ITEMS  = 1100;
    localparam int SHOW_LIMIT    = 10;

    // op codes with no function in the block
    localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

    // one request as it crosses the input channel
    typedef struct packed {
        logic [OP_BITS-1:0]       op;
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] pri;
        logic                     pers;
        logic                     sent_ok;
        logic [INDEX_BITS-1:0]    index;
    } t_outbox_req;

    // one reply as it crosses the output channel
    typedef struct packed {
        logic                     found;
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] pri;
        logic                     pers;
        logic                     in_flight;
        logic [CNT_W-1:0]         count;
        logic                     error;
    } t_outbox_reply;

    // shadow outbox: predicts each reply on request transfer, checks replies in order
    class outbox_scoreboard;
        t_entry                   slots [QUEUE_DEPTH];
        int                       used;
        bit                       sending;
        logic [PRIORITY_BITS-1:0] normal_pri;
        t_outbox_reply            replies_due [$];
        int                       mismatches;

        function new();
            used       = 0;
            sending    = 1'b0;
            normal_pri = PRIORITY_BITS'(1);
            mismatches = 0;
        endfunction

        function void set_normal(logic [PRIORITY_BITS-1:0] value);
            normal_pri = value;
        endfunction

        // close the gap left by a removed entry
        function void drop_slot(int pos);
            int k;
            for (k = pos; k + 1 < used; k++) begin
                slots[k] = slots[k + 1];
            end
            used--;
        endfunction

        function string show(t_outbox_reply r);
            return $sformatf("found=%0d id=%h pri=%0d pers=%0d flight=%0d count=%0d err=%0d",
                             r.found, r.id, r.pri, r.pers, r.in_flight, r.count, r.error);
        endfunction

        function void note_request(t_outbox_req rq);
            t_outbox_reply r;
            int            pos;
            int            k;
            int            pick;
            bit            give;
            r    = '0;
            give = 1'b0;
            pick = 0;
            case (rq.op)
                OP_ADD: begin
                    if (used >= QUEUE_DEPTH) begin
                        r.error = 1'b1;
                    end else begin
                        pos = used;
                        if (rq.pri != normal_pri) begin
                            for (k = 0; k < used; k++) begin
                                if (slots[k].pri < rq.pri) begin
                                    // never jump ahead of a head that is being sent
                                    pos = (sending && k == 0) ? 1 : k;
                                    break;
                                end
                            end
                        end
                        for (k = used; k > pos; k--) begin
                            slots[k] = slots[k - 1];
                        end
                        slots[pos].id   = rq.id;
                        slots[pos].pri  = rq.pri;
                        slots[pos].pers = rq.pers;
                        used++;
                    end
                end
                OP_GET_NEXT: begin
                    if (used > 0) begin
                        sending = 1'b1;
                        give    = 1'b1;
                    end
                end
                OP_MARK: begin
                    if (rq.sent_ok && sending && used > 0) begin
                        drop_slot(0);
                    end
                    sending = 1'b0;
                end
                OP_CLEAR: begin
                    for (k = used - 1; k >= 0; k--) begin
                        if (!slots[k].pers) begin
                            drop_slot(k);
                        end
                    end
                end
                OP_CONTAINS: begin
                    for (k = 0; k < used; k++) begin
                        if (slots[k].pri == rq.pri) begin
                            r.found = 1'b1;
                        end
                    end
                end
                OP_READ: begin
                    if (rq.index < used) begin
                        pick = int'(rq.index);
                        give = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (give) begin
                r.found = 1'b1;
                r.id    = slots[pick].id;
                r.pri   = slots[pick].pri;
                r.pers  = slots[pick].pers;
            end
            r.in_flight = sending;
            r.count     = CNT_W'(used);
            replies_due.push_back(r);
        endfunction

        function void check_reply(t_outbox_reply got);
            t_outbox_reply want;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT) begin
                    $display("unexpected reply: %s", show(got));
                end
                return;
            end
            want = replies_due.pop_front();
            if (got.found !== want.found || got.id !== want.id || got.pri !== want.pri ||
                got.pers !== want.pers || got.in_flight !== want.in_flight ||
                got.count !== want.count || got.error !== want.error) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT) begin
                    $display("mismatch: expected %s", show(want));
                    $display("          actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_cfg_valid      = 1'b0;
    logic                     o_cfg_ready;
    logic [PRIORITY_BITS-1:0] i_cfg_data       = '0;
    logic                     i_in_valid       = 1'b0;
    logic                     o_in_ready;
    logic [OP_BITS-1:0]       i_op             = '0;
    logic [ID_BITS-1:0]       i_message_id     = '0;
    logic [PRIORITY_BITS-1:0] i_priority_req   = '0;
    logic                     i_persistent     = 1'b0;
    logic                     i_sent_ok        = 1'b0;
    logic [INDEX_BITS-1:0]    i_index          = '0;
    logic                     o_out_valid;
    logic                     i_out_ready      = 1'b0;
    logic                     o_found;
    logic [ID_BITS-1:0]       o_out_id;
    logic [PRIORITY_BITS-1:0] o_out_priority;
    logic                     o_out_persistent;
    logic                     o_in_flight;
    logic [CNT_W-1:0]         o_entry_count;
    logic                     o_error;

    outbox_scoreboard sb;
    int  requests_sent = 0;
    bit  quiet_run     = 1'b0;   // no random idling on either side while set
    bit  hold_go       = 1'b0;   // asks the receiver for one long hold-off
    bit  hold_served   = 1'b0;
    int  stall_count   = 0;

    priority_outbox_queue_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_message_id     (i_message_id),
        .i_priority_req   (i_priority_req),
        .i_persistent     (i_persistent),
        .i_sent_ok        (i_sent_ok),
        .i_index          (i_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_out_id         (o_out_id),
        .o_out_priority   (o_out_priority),
        .o_out_persistent (o_out_persistent),
        .o_in_flight      (o_in_flight),
        .o_entry_count    (o_entry_count),
        .o_error          (o_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_served) begin
                hold_served = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= quiet_run || ($urandom_range(99) >= 29);
            end
        end
    end

    // every reply transfer is checked against the oldest prediction
    always @(posedge i_clk) begin : reply_monitor
        t_outbox_reply seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.found     = o_found;
            seen.id        = o_out_id;
            seen.pri       = o_out_priority;
            seen.pers      = o_out_persistent;
            seen.in_flight = o_in_flight;
            seen.count     = o_entry_count;
            seen.error     = o_error;
            sb.check_reply(seen);
        end
    end

    // watchdog: any transfer on any channel restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("priority_outbox_queue_core test failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    function automatic t_outbox_req random_request(logic [OP_BITS-1:0] op);
        t_outbox_req rq;
        rq.op      = op;
        rq.id      = ID_BITS'($urandom);
        rq.pri     = PRIORITY_BITS'($urandom_range(3));
        rq.pers    = 1'($urandom_range(1));
        rq.sent_ok = 1'($urandom_range(1));
        rq.index   = INDEX_BITS'($urandom_range(15));
        return rq;
    endfunction

    // offer one request, hold it until the transfer, then maybe idle a while
    task automatic push_request(t_outbox_req rq);
        i_in_valid     <= 1'b1;
        i_op           <= rq.op;
        i_message_id   <= rq.id;
        i_priority_req <= rq.pri;
        i_persistent   <= rq.pers;
        i_sent_ok      <= rq.sent_ok;
        i_index        <= rq.index;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(rq);
        if (rq.op <= OP_READ) begin
            requests_sent++;
        end
        if (!quiet_run) begin
            while ($urandom_range(99) < 29) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic push_add(logic [ID_BITS-1:0] id, logic [PRIORITY_BITS-1:0] pri, logic pers);
        t_outbox_req rq;
        rq      = random_request(OP_ADD);
        rq.id   = id;
        rq.pri  = pri;
        rq.pers = pers;
        push_request(rq);
    endtask

    // stop offering and let the block drain completely
    task automatic drain_outbox();
        i_in_valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_normal(logic [PRIORITY_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_normal(value);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_checks();
        t_outbox_req rq;
        // empty outbox: get next, mark sent, read, query, unused codes
        push_request(random_request(OP_GET_NEXT));
        rq = random_request(OP_MARK);
        rq.sent_ok = 1'b1;
        push_request(rq);
        rq = random_request(OP_READ);
        rq.index = '0;
        push_request(rq);
        push_request(random_request(OP_CONTAINS));
        push_request(random_request(OP_SPARE_LO));
        push_request(random_request(OP_SPARE_HI));
        // field extremes and ordered insert
        push_add(16'hFFFF, 2'd3, 1'b1);
        push_add(16'h0000, 2'd0, 1'b0);
        push_add(16'h1234, 2'd1, 1'b0);
        push_add(16'h5A5A, 2'd2, 1'b0);
        // failed send keeps the head, successful one removes it
        push_request(random_request(OP_GET_NEXT));
        rq = random_request(OP_MARK);
        rq.sent_ok = 1'b0;
        push_request(rq);
        push_request(random_request(OP_GET_NEXT));
        rq = random_request(OP_MARK);
        rq.sent_ok = 1'b1;
        push_request(rq);
        // insert point at the head while a send is in flight
        push_request(random_request(OP_GET_NEXT));
        push_add(16'hA5A5, 2'd3, 1'b1);
        rq = random_request(OP_READ);
        rq.index = 4'd1;
        push_request(rq);
        rq = random_request(OP_CONTAINS);
        rq.pri = 2'd3;
        push_request(rq);
        rq = random_request(OP_CONTAINS);
        rq.pri = 2'd0;
        push_request(rq);
        // clear while in flight drops the non-persistent head
        push_request(random_request(OP_CLEAR));
        rq = random_request(OP_MARK);
        rq.sent_ok = 1'b1;
        push_request(rq);
        rq = random_request(OP_READ);
        rq.index = 4'd15;
        push_request(rq);
    endtask

    // random traffic built from well-formed send cycles, bursts and queries, plus noise
    task automatic random_phase(int target);
        t_outbox_req rq;
        int          pick;
        int          extra;
        while (requests_sent < target) begin
            pick = $urandom_range(99);
            if (sb.used >= 12 && pick < 50) begin
                pick = 0;
            end
            if (pick < 30) begin
                push_request(random_request(OP_GET_NEXT));
                extra = $urandom_range(2);
                repeat (extra) begin
                    push_request(random_request($urandom_range(1) ? OP_ADD : OP_READ));
                end
                rq = random_request(OP_MARK);
                rq.sent_ok = ($urandom_range(99) < 80);
                push_request(rq);
            end else if (pick < 50) begin
                repeat ($urandom_range(6, 1)) push_request(random_request(OP_ADD));
            end else if (pick < 58) begin
                // fill to the top, then overflow a little
                while (sb.used < QUEUE_DEPTH) push_request(random_request(OP_ADD));
                repeat ($urandom_range(2, 1)) push_request(random_request(OP_ADD));
            end else if (pick < 73) begin
                if ($urandom_range(1)) begin
                    push_request(random_request(OP_CONTAINS));
                end else begin
                    rq = random_request(OP_READ);
                    if (sb.used > 0 && $urandom_range(99) < 80) begin
                        rq.index = INDEX_BITS'($urandom_range(sb.used - 1));
                    end
                    push_request(rq);
                end
            end else if (pick < 80) begin
                push_request(random_request(OP_CLEAR));
            end else begin
                push_request(random_request(OP_BITS'($urandom_range(7))));
            end
        end
    endtask

    initial begin
        int phase;
        int target;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_checks();
        drain_outbox();

        target = requests_sent;
        phase  = 0;
        while (target < RANDOM_ITEMS - 55) begin
            // first phases walk the normal priority through both extremes
            case (phase)
                0:       write_normal(2'd0);
                1:       write_normal(2'd3);
                2:       write_normal(2'd2);
                3:       write_normal(2'd1);
                default: write_normal(PRIORITY_BITS'($urandom_range(3)));
            endcase
            quiet_run = (phase == 1 || phase == 2 || phase == 6);
            if (phase == 2) begin
                // receiver holds off while the sender keeps offering
                hold_go <= 1'b1;
            end
            target += 110;
            random_phase(target);
            drain_outbox();
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.replies_due.size() == 0) begin
            $display("priority_outbox_queue_core test passed");
        end else begin
            $display("priority_outbox_queue_core test failed");
        end
        $finish;
    end

endmodule
